/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sorter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/ais_pkg.sv */
// ----------------------------------------------------------------------------
// Ascending integer sorter package
// Sizes shared by the sorter and its element store.
// ----------------------------------------------------------------------------
package ais_pkg;

    // Capacity of the element store
    localparam int MAX_ENTRIES = 16;

    // Element width
    localparam int VAL_W = 16;

    // Store index width and element count width (count can reach MAX_ENTRIES)
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef logic [VAL_W-1:0] val_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

endpackage

/* sv/ais_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ais_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, read every cycle (old data on address collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/ascending_integer_sorter.sv */
// ----------------------------------------------------------------------------
// Ascending integer sorter
// Collects a set of unsigned values and emits them in ascending order.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Ports
//  input     start & !busy          value, last
//  result    strobe (no backpress)  sorted_value, end_of_set, overflow
//
//  An element into an empty store is written, or into a full store dropped, as
//  it is accepted; otherwise the insert walks down from the top entry, one
//  compare-and-shift step per larger element, set by the single read port of
//  the element store and one comparator. A closing element then starts the
//  read-out; results follow back to back, each in the cycle after its store read.
//  Reset clears count and flags at once, but not overflow or the store.
//  Results cannot be stalled; busy stays high until the last read is issued.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ascending_integer_sorter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ais_pkg::val_t        value,
    input  logic                 last,
    output logic                 strobe,
    output ais_pkg::val_t        sorted_value,
    output logic                 end_of_set,
    output logic                 overflow
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CMP   = 2'd1;
    localparam logic [1:0] ST_PLACE = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam ais_pkg::cnt_t CNT_FULL = ais_pkg::cnt_t'(ais_pkg::MAX_ENTRIES);
    localparam ais_pkg::cnt_t CNT_ONE  = ais_pkg::cnt_t'(1);
    localparam ais_pkg::cnt_t CNT_TWO  = ais_pkg::cnt_t'(2);

    logic [1:0]    state_reg, state_next;
    ais_pkg::cnt_t count_reg, count_next;
    ais_pkg::cnt_t pos_reg,   pos_next;
    ais_pkg::cnt_t k_reg,     k_next;
    logic          dropped_reg, dropped_next;
    logic          last_reg,    last_next;
    ais_pkg::val_t value_reg,   value_next;
    logic          strobe_reg,  strobe_next;
    logic          end_reg,     end_next;
    logic          ovf_reg,     ovf_next;

    logic          ram_we;
    ais_pkg::idx_t ram_wr_addr;
    ais_pkg::val_t ram_wr_data;
    ais_pkg::idx_t ram_rd_addr;
    ais_pkg::val_t ram_rd_data;

    logic          accept;
    logic          greater;
    ais_pkg::cnt_t count_m1;
    ais_pkg::cnt_t pos_m2;
    ais_pkg::cnt_t k_p1;

    assign accept   = start && (state_reg == ST_IDLE);
    assign count_m1 = count_reg - CNT_ONE;
    assign pos_m2   = pos_reg - CNT_TWO;
    assign k_p1     = k_reg + CNT_ONE;

    // Shared comparator: stored element against the element being inserted
    assign greater = ram_rd_data > value_reg;

    // Element store
    ais_ram #(
        .WIDTH (ais_pkg::VAL_W),
        .DEPTH (ais_pkg::MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sequencer: insert one element at a time, then read the set out
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        k_next       = k_reg;
        dropped_next = dropped_reg;
        last_next    = last_reg;
        value_next   = value_reg;
        strobe_next  = 1'b0;
        end_next     = 1'b0;
        ovf_next     = ovf_reg;
        ram_we       = 1'b0;
        ram_wr_addr  = pos_reg[ais_pkg::IDX_W-1:0];
        ram_wr_data  = value_reg;
        ram_rd_addr  = count_m1[ais_pkg::IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_next = value;
                    last_next  = last;
                    k_next     = '0;
                    if (count_reg == CNT_FULL)
                    begin
                        // Drop the element, flag the set
                        dropped_next = 1'b1;
                        state_next   = last ? ST_EMIT : ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        // Empty store: write straight to the first entry
                        ram_we      = 1'b1;
                        ram_wr_addr = '0;
                        ram_wr_data = value;
                        count_next  = CNT_ONE;
                        state_next  = last ? ST_EMIT : ST_IDLE;
                    end
                    else
                    begin
                        // Read the top entry, start the compare walk
                        pos_next   = count_reg;
                        state_next = ST_CMP;
                    end
                end
            end

            ST_CMP:
            begin
                ram_we = 1'b1;
                if (greater)
                begin
                    // Shift the larger element up one place
                    ram_wr_data = ram_rd_data;
                    pos_next    = pos_reg - CNT_ONE;
                    ram_rd_addr = pos_m2[ais_pkg::IDX_W-1:0];
                    if (pos_reg == CNT_ONE)
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    // Slot found: place the new element
                    count_next = count_reg + CNT_ONE;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end

            ST_PLACE:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_ONE;
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end

            ST_EMIT:
            begin
                // Issue one read per cycle, result shows the cycle after
                ram_rd_addr = k_reg[ais_pkg::IDX_W-1:0];
                strobe_next = 1'b1;
                end_next    = (k_p1 == count_reg);
                ovf_next    = dropped_reg;
                k_next      = k_p1;
                if (k_p1 == count_reg)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            strobe_reg  <= 1'b0;
            end_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            strobe_reg  <= strobe_next;
            end_reg     <= end_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        k_reg     <= k_next;
        last_reg  <= last_next;
        value_reg <= value_next;
        ovf_reg   <= ovf_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign strobe       = strobe_reg;
    assign sorted_value = ram_rd_data;
    assign end_of_set   = end_reg;
    assign overflow     = ovf_reg;

    // Checks
    `ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_FULL)
    `ASSERT_SAME(a_walk_pos, clk, rst_n, state_reg == ST_CMP,
        (pos_reg != '0) && (pos_reg <= count_reg) && (count_reg != CNT_FULL))
    `ASSERT_NEXT(a_results_contiguous, clk, rst_n, strobe && !end_of_set, strobe)
    `ASSERT_SAME(a_end_needs_strobe, clk, rst_n, end_of_set, strobe)

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// Ascending integer sorter testbench
// Drives sets of values with bursty start timing, predicts the sorted output
// of each set, and checks every result transaction field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 420;
    localparam int DRAIN_CYCLES = 40;

    // Value patterns for random sets
    typedef enum int {
        PAT_FULL,
        PAT_NARROW,
        PAT_CORNER
    } value_pattern_t;

    typedef struct {
        ais_pkg::val_t value;
        logic          end_of_set;
        logic          overflow;
    } sorted_result_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    ais_pkg::val_t value;
    logic          last;
    logic          strobe;
    ais_pkg::val_t sorted_value;
    logic          end_of_set;
    logic          overflow;

    // Predicted set contents
    ais_pkg::val_t model_store [ais_pkg::MAX_ENTRIES];
    int            model_count;
    logic          model_dropped;

    sorted_result_t expected_sorted [$];

    int error_count;
    int items_sent;
    int burst_left;

    // Result captured at the rising edge, checked at the falling edge
    logic          cap_valid;
    ais_pkg::val_t cap_value;
    logic          cap_end;
    logic          cap_ovf;

    ascending_integer_sorter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .end_of_set   (end_of_set),
        .overflow     (overflow)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        begin
            $display("MISMATCH %s: expected %0h, got %0h", what, exp_v, got_v);
            error_count++;
        end
    endtask

    // Insert one element into the predicted set; on the closing element,
    // queue the whole set in ascending order and clear for the next one
    task automatic absorb_element(input ais_pkg::val_t v, input logic is_last);
        int pos;
        sorted_result_t r;
        begin
            if (model_count < ais_pkg::MAX_ENTRIES)
            begin
                pos = model_count;
                while (pos > 0 && model_store[pos-1] > v)
                begin
                    model_store[pos] = model_store[pos-1];
                    pos--;
                end
                model_store[pos] = v;
                model_count++;
            end
            else
            begin
                model_dropped = 1'b1;
            end
            if (is_last)
            begin
                for (int k = 0; k < model_count; k++)
                begin
                    r.value      = model_store[k];
                    r.end_of_set = (k + 1 == model_count);
                    r.overflow   = model_dropped;
                    expected_sorted.push_back(r);
                end
                model_count   = 0;
                model_dropped = 1'b0;
            end
        end
    endtask

    // Send one element transaction, inserting a random gap between bursts
    task automatic send_element(input ais_pkg::val_t v, input logic is_last);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 8);
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                if ($urandom_range(0, 4) == 0)
                    burst_left = $urandom_range(20, 60);
                else
                    burst_left = $urandom_range(1, 12);
            end
            @(negedge clk);
            start <= 1'b1;
            value <= v;
            last  <= is_last;
            do
                @(posedge clk);
            while (busy);
            absorb_element(v, is_last);
            items_sent++;
            burst_left--;
        end
    endtask

    function automatic ais_pkg::val_t pick_value(input value_pattern_t pat);
        ais_pkg::val_t v;
        begin
            case (pat)
                PAT_NARROW: v = ais_pkg::val_t'($urandom_range(0, 7));
                PAT_CORNER:
                begin
                    case ($urandom_range(0, 3))
                        0:       v = 16'h0000;
                        1:       v = 16'hFFFF;
                        2:       v = 16'h8000;
                        default: v = 16'h7FFF;
                    endcase
                end
                default:    v = ais_pkg::val_t'($urandom);
            endcase
            return v;
        end
    endfunction

    // Sets of one element at both value extremes
    task automatic test_single_elements();
        begin
            send_element(16'h0000, 1'b1);
            send_element(16'hFFFF, 1'b1);
        end
    endtask

    // Reverse-ordered set spanning the full range
    task automatic test_descending_set();
        begin
            send_element(16'hFFFF, 1'b0);
            send_element(16'h7FFF, 1'b0);
            send_element(16'h0000, 1'b1);
        end
    endtask

    // Equal values stay as adjacent duplicates
    task automatic test_duplicates();
        begin
            send_element(16'h0005, 1'b0);
            send_element(16'h0003, 1'b0);
            send_element(16'h0005, 1'b1);
        end
    endtask

    // Fill the store, then close with an element that is dropped
    task automatic test_overflow();
        begin
            for (int k = 0; k < ais_pkg::MAX_ENTRIES; k++)
                send_element(ais_pkg::val_t'($urandom), 1'b0);
            send_element(ais_pkg::val_t'($urandom), 1'b1);
        end
    endtask

    // Random sets, mostly small, some full, some past capacity
    task automatic test_random_sets();
        int sel;
        int set_len;
        value_pattern_t pat;
        begin
            while (items_sent < RANDOM_ITEMS)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 65)
                    set_len = $urandom_range(1, 6);
                else if (sel < 88)
                    set_len = $urandom_range(7, ais_pkg::MAX_ENTRIES);
                else
                    set_len = $urandom_range(ais_pkg::MAX_ENTRIES, ais_pkg::MAX_ENTRIES + 4);
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    pat = PAT_FULL;
                else if (sel < 8)
                    pat = PAT_NARROW;
                else
                    pat = PAT_CORNER;
                for (int k = 0; k < set_len; k++)
                    send_element(pick_value(pat), k == set_len - 1);
            end
        end
    endtask

    // Capture each result transaction at the edge that accepts it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_valid <= 1'b0;
            cap_value <= '0;
            cap_end   <= 1'b0;
            cap_ovf   <= 1'b0;
        end
        else
        begin
            cap_valid <= strobe;
            cap_value <= sorted_value;
            cap_end   <= end_of_set;
            cap_ovf   <= overflow;
        end
    end

    // Compare captured result against the oldest prediction
    always @(negedge clk)
    begin
        sorted_result_t exp_r;
        if (cap_valid)
        begin
            if (expected_sorted.size() == 0)
            begin
                report_mismatch("unexpected result", 0, int'(cap_value));
            end
            else
            begin
                exp_r = expected_sorted.pop_front();
                if (cap_value !== exp_r.value)
                    report_mismatch("sorted_value", int'(exp_r.value), int'(cap_value));
                if (cap_end !== exp_r.end_of_set)
                    report_mismatch("end_of_set", int'(exp_r.end_of_set), int'(cap_end));
                if (cap_ovf !== exp_r.overflow)
                    report_mismatch("overflow", int'(exp_r.overflow), int'(cap_ovf));
            end
        end
    end

    // Stop the run when nothing moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || strobe)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("ascending_integer_sorter verification failed");
        $finish;
    end

    // Reset, run each test in turn, drain and report
    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        value         = '0;
        last          = 1'b0;
        error_count   = 0;
        items_sent    = 0;
        burst_left    = 0;
        model_count   = 0;
        model_dropped = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_elements();
        test_descending_set();
        test_duplicates();
        test_overflow();
        test_random_sets();

        @(negedge clk);
        start <= 1'b0;
        while (expected_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("ascending_integer_sorter verification clean");
        else
            $display("ascending_integer_sorter verification failed");
        $finish;
    end

endmodule
